[rtl/bbgs_pkg.sv]
// ----------------------------------------------------------------------------
// bbgs_pkg
// Shared types and constants for the three-state cellular automaton block:
// field widths, cell codes, item modes and register indexes.
// ----------------------------------------------------------------------------
package bbgs_pkg;

  // Field widths of one request and one result
  localparam int CELL_W = 2;
  localparam int MODE_W = 2;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;

  // Configuration port
  localparam int CFG_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd64;
  localparam logic [CFG_W-1:0] GRID_SIZE_MIN = 7'd3;

  // Default grid storage
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Cell states
  typedef enum logic [CELL_W-1:0] {
    CELL_OFF   = 2'd0,
    CELL_ON    = 2'd1,
    CELL_DYING = 2'd2
  } cell_e;

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2
  } mode_e;

  // Register indexes
  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_e;

endpackage

[rtl/bbgs_row_calc.sv]
// ----------------------------------------------------------------------------
// bbgs_row_calc
// Next generation of one grid row from the row above, the row itself and
// the row below, with horizontal wrap at the width in use.
// ----------------------------------------------------------------------------
module bbgs_row_calc import bbgs_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic [CELL_W*MAX_WIDTH-1:0]     row_up_i,
  input  logic [CELL_W*MAX_WIDTH-1:0]     row_mid_i,
  input  logic [CELL_W*MAX_WIDTH-1:0]     row_dn_i,
  input  logic [$clog2(MAX_WIDTH):0]      width_i,
  output logic [CELL_W*MAX_WIDTH-1:0]     row_new_o
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic [MAX_WIDTH-1:0] on_up;
  logic [MAX_WIDTH-1:0] on_mid;
  logic [MAX_WIDTH-1:0] on_dn;
  logic [XW:0]          width_m1;
  logic [XW-1:0]        last_col;

  // Column that wraps around to the left of column zero
  assign width_m1 = width_i - (XW+1)'(1);
  assign last_col = width_m1[XW-1:0];

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : gen_cell
    localparam logic [XW:0] XPOS = (XW+1)'(x);
    localparam int XR = (x == MAX_WIDTH-1) ? 0 : x + 1;

    logic [CELL_W-1:0] cur;
    logic [CELL_W-1:0] nxt;
    logic              l_up, l_mid, l_dn;
    logic              r_up, r_mid, r_dn;
    logic              wrap_r;
    logic [3:0]        cnt;

    // Flag cells that are on
    assign on_up[x]  = (row_up_i[CELL_W*x +: CELL_W] == CELL_ON);
    assign on_mid[x] = (row_mid_i[CELL_W*x +: CELL_W] == CELL_ON);
    assign on_dn[x]  = (row_dn_i[CELL_W*x +: CELL_W] == CELL_ON);
    assign cur       = row_mid_i[CELL_W*x +: CELL_W];

    // Left neighbors, wrapping from the first column to the last in use
    if (x == 0) begin : gen_left_wrap
      assign l_up  = on_up[last_col];
      assign l_mid = on_mid[last_col];
      assign l_dn  = on_dn[last_col];
    end else begin : gen_left
      assign l_up  = on_up[x-1];
      assign l_mid = on_mid[x-1];
      assign l_dn  = on_dn[x-1];
    end

    // Right neighbors, wrapping from the last column in use to the first
    assign wrap_r = ((XPOS + (XW+1)'(1)) == width_i);
    assign r_up   = wrap_r ? on_up[0]  : on_up[XR];
    assign r_mid  = wrap_r ? on_mid[0] : on_mid[XR];
    assign r_dn   = wrap_r ? on_dn[0]  : on_dn[XR];

    // Count live neighbors
    assign cnt = 4'(l_up) + 4'(on_up[x]) + 4'(r_up) + 4'(l_mid) + 4'(r_mid)
               + 4'(l_dn) + 4'(on_dn[x]) + 4'(r_dn);

    // Apply the transition rule, hold cells beyond the width in use
    always_comb begin
      unique case (cur)
        CELL_OFF: nxt = (cnt == 4'd2) ? CELL_ON : CELL_OFF;
        CELL_ON:  nxt = CELL_DYING;
        default:  nxt = CELL_OFF;
      endcase
      if (XPOS >= width_i) begin
        nxt = cur;
      end
    end

    assign row_new_o[CELL_W*x +: CELL_W] = nxt;
  end

endmodule

[rtl/brians_brain_generation_step.sv]
// ----------------------------------------------------------------------------
// brians_brain_generation_step
// Three-state cellular automaton on a wrapped grid held in a row memory,
// with single-cell write and read and whole-grid generation steps.
// ----------------------------------------------------------------------------
// After reset the block clears all MAX_HEIGHT rows of the grid memory, one row
// per cycle, with busy_o high. A write or read inside the grid keeps busy_o
// high for one cycle: the row is read into the read register, then, for a
// write, modified and written back, and the result strobe is registered. A
// write or read outside the grid, or an unused mode, is answered in the next
// cycle without raising busy_o, so such requests may follow each other every
// cycle. During a generation step the row memory's read port streams one row
// per cycle through a three-row window while each new row is written back in
// place. The result strobe is a single cycle wide and cannot be held off. Grid
// size registers are to be written only while idle; the block does not check.
// ----------------------------------------------------------------------------
module brians_brain_generation_step import bbgs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel
  input  logic              start_i,
  output logic              busy_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [CELL_W-1:0] cell_value_i,
  // Result channel
  output logic              result_valid_o,
  output logic [CELL_W-1:0] cell_state_o,
  output logic              out_of_range_o,
  output logic              done_res_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int RW = CELL_W * MAX_WIDTH;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CELL  = 4'b0100,
    S_STEP  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [YW:0]       k_q, k_d;
  logic [CFG_W-1:0]  grid_width_q, grid_width_d;
  logic [CFG_W-1:0]  grid_height_q, grid_height_d;
  logic [XW:0]       w_eff;
  logic [YW:0]       h_eff;
  logic              cfg_we;
  logic              in_range;
  logic              accept;

  // Latched request
  logic              wr_cell_q;
  logic [XW-1:0]     col_q;
  logic [YW-1:0]     row_q;
  logic [CELL_W-1:0] val_q;
  logic [CELL_W-1:0] val_in;

  // Result registers
  logic              res_valid_q, res_valid_d;
  logic [CELL_W-1:0] res_state_q, res_state_d;
  logic              res_oor_q, res_oor_d;
  logic              res_done_q, res_done_d;

  // Row memory and sweep window
  logic [RW-1:0]     mem_q [MAX_HEIGHT];
  logic [RW-1:0]     rd_q;
  logic [RW-1:0]     prev_q, cur_q, row0_q;
  logic [RW-1:0]     dn_row;
  logic [RW-1:0]     calc_row;
  logic [RW-1:0]     mod_row;
  logic              we;
  logic [YW-1:0]     waddr, raddr;
  logic [RW-1:0]     wdata;
  logic [YW:0]       k_last;
  logic [YW:0]       k_m1, k_m3, h_m1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_we) begin
      unique case (reg_e'(paddr[APB_AW-1]))
        REG_GRID_WIDTH:  grid_width_d  = pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height_d = pwdata[CFG_W-1:0];
        default:         grid_width_d  = grid_width_q;
      endcase
    end
  end

  assign prdata = paddr[APB_AW-1] ? APB_DW'(grid_height_q) : APB_DW'(grid_width_q);

  // Clamp the sizes in use to the minimum grid size and to the storage
  always_comb begin
    if (grid_width_q < GRID_SIZE_MIN) begin
      w_eff = (XW+1)'(GRID_SIZE_MIN);
    end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(grid_width_q);
    end
    if (grid_height_q < GRID_SIZE_MIN) begin
      h_eff = (YW+1)'(GRID_SIZE_MIN);
    end else if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(grid_height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i & ~busy_o;
  assign in_range = (32'(column_i) < 32'(w_eff)) && (32'(row_i) < 32'(h_eff));
  assign val_in   = (cell_value_i == CELL_ON || cell_value_i == CELL_DYING) ?
                    cell_value_i : CELL_OFF;

  // Sweep indexes
  assign k_last = h_eff + (YW+1)'(2);
  assign k_m1   = k_q - (YW+1)'(1);
  assign k_m3   = k_q - (YW+1)'(3);
  assign h_m1   = h_eff - (YW+1)'(1);

  // Bottom neighbor row: memory data, or saved first row for the last row
  assign dn_row = (k_q == k_last) ? row0_q : rd_q;

  bbgs_row_calc #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_row_calc (
    .row_up_i  (prev_q),
    .row_mid_i (cur_q),
    .row_dn_i  (dn_row),
    .width_i   (w_eff),
    .row_new_o (calc_row)
  );

  // Replace one cell in the fetched row
  always_comb begin
    mod_row = rd_q;
    mod_row[{col_q, 1'b0} +: CELL_W] = val_q;
  end

  // Read address
  always_comb begin
    raddr = '0;
    unique case (state_q)
      S_IDLE: raddr = YW'(row_i);
      S_STEP: begin
        if (k_q == '0) begin
          raddr = h_m1[YW-1:0];
        end else if (k_q <= h_eff) begin
          raddr = k_m1[YW-1:0];
        end
      end
      default: raddr = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    res_valid_d = 1'b0;
    res_state_d = res_state_q;
    res_oor_d   = res_oor_q;
    res_done_d  = res_done_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = calc_row;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = k_q[YW-1:0];
        wdata = '0;
        if (k_q == (YW+1)'(MAX_HEIGHT - 1)) begin
          k_d     = '0;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + (YW+1)'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_state_d = CELL_OFF;
          res_oor_d   = 1'b0;
          res_done_d  = 1'b1;
          unique case (mode_i)
            MODE_WRITE, MODE_READ: begin
              if (in_range) begin
                state_d = S_CELL;
              end else begin
                res_valid_d = 1'b1;
                res_oor_d   = 1'b1;
              end
            end
            MODE_STEP: begin
              k_d     = '0;
              state_d = S_STEP;
            end
            default: begin
              res_valid_d = 1'b1;
              res_done_d  = 1'b0;
            end
          endcase
        end
      end
      S_CELL: begin
        res_valid_d = 1'b1;
        res_oor_d   = 1'b0;
        res_done_d  = 1'b1;
        res_state_d = wr_cell_q ? CELL_OFF : rd_q[{col_q, 1'b0} +: CELL_W];
        we          = wr_cell_q;
        waddr       = row_q;
        wdata       = mod_row;
        state_d     = S_IDLE;
      end
      S_STEP: begin
        k_d = k_q + (YW+1)'(1);
        if (k_q >= (YW+1)'(3)) begin
          we    = 1'b1;
          waddr = k_m3[YW-1:0];
          wdata = calc_row;
        end
        if (k_q == k_last) begin
          res_valid_d = 1'b1;
          res_state_d = CELL_OFF;
          res_oor_d   = 1'b0;
          res_done_d  = 1'b1;
          k_d         = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        k_d     = '0;
        state_d = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      k_q           <= '0;
      grid_width_q  <= GRID_SIZE_RST;
      grid_height_q <= GRID_SIZE_RST;
      res_valid_q   <= 1'b0;
      res_state_q   <= CELL_OFF;
      res_oor_q     <= 1'b0;
      res_done_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      k_q           <= k_d;
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
      res_valid_q   <= res_valid_d;
      res_state_q   <= res_state_d;
      res_oor_q     <= res_oor_d;
      res_done_q    <= res_done_d;
    end
  end

  // Capture the request fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_cell_q <= (mode_i == MODE_WRITE);
      col_q     <= XW'(column_i);
      row_q     <= YW'(row_i);
      val_q     <= val_in;
    end
  end

  // Shift the three-row window during a step
  always_ff @(posedge clk_i) begin
    if (state_q == S_STEP) begin
      if (k_q == (YW+1)'(1)) begin
        prev_q <= rd_q;
      end else if (k_q == (YW+1)'(2)) begin
        cur_q  <= rd_q;
        row0_q <= rd_q;
      end else if (k_q >= (YW+1)'(3) && k_q < k_last) begin
        prev_q <= cur_q;
        cur_q  <= rd_q;
      end
    end
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Drive the result
  assign result_valid_o = res_valid_q;
  assign cell_state_o   = res_state_q;
  assign out_of_range_o = res_oor_q;
  assign done_res_o     = res_done_q;

endmodule

[rtl/bbgs_checker.sv]
// ----------------------------------------------------------------------------
// bbgs_checker
// Port-level checks of the request and result channels of the automaton
// block, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module bbgs_checker import bbgs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input logic [CELL_W-1:0] cell_state_o,
  input logic              out_of_range_o,
  input logic              done_res_o
);

  // A result never shows while a request is still at work
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // Busy rises only after a request
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request");

  // Out-of-range results carry no cell state and count as done
  a_oor_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |-> (done_res_o && cell_state_o == CELL_OFF))
    else $error("out-of-range result malformed");

  // Results of unused modes are empty
  a_undone_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !done_res_o) |-> (!out_of_range_o && cell_state_o == CELL_OFF))
    else $error("not-done result carries data");

  // Results never hold the unused cell code
  a_cell_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (cell_state_o == CELL_OFF || cell_state_o == CELL_ON || cell_state_o == CELL_DYING))
    else $error("result cell state out of range");

endmodule

bind brians_brain_generation_step bbgs_checker u_bbgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .cell_state_o   (cell_state_o),
  .out_of_range_o (out_of_range_o),
  .done_res_o     (done_res_o)
);
